### rtl/text_animation_frame_parser_unit_macros.svh
// Assertion macros used by the checker of the animation frame parser.
`ifndef TEXT_ANIMATION_FRAME_PARSER_UNIT_MACROS_SVH
`define TEXT_ANIMATION_FRAME_PARSER_UNIT_MACROS_SVH

// Antecedent true implies consequent true in the same cycle.
`define TAFP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tafp same-cycle check failed");

// Antecedent true implies consequent true in the next cycle.
`define TAFP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tafp next-cycle check failed");

`endif

### rtl/tafp_pkg.sv
// Types, codes and helper functions of the animation frame parser.
package tafp_pkg;

    // Parser phases, one-hot.
    typedef enum logic [3:0] {
        PH_HEADER  = 4'b0001,
        PH_OPTIONS = 4'b0010,
        PH_CONTENT = 4'b0100,
        PH_ERROR   = 4'b1000
    } phase_t;

    // Result kinds.
    localparam logic [1:0] KIND_FRAME  = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;

    // End report status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_MAGIC     = 3'd1;
    localparam logic [2:0] ST_HEX       = 3'd2;
    localparam logic [2:0] ST_OPTION    = 3'd3;
    localparam logic [2:0] ST_LENGTH    = 3'd4;
    localparam logic [2:0] ST_TRUNCATED = 3'd5;

    // Special characters.
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_BAR     = 8'h7C;
    localparam logic [7:0] CH_FULL    = 8'h46;
    localparam logic [7:0] CH_REVERSE = 8'h52;
    localparam logic [7:0] RATE_DEFAULT = 8'd4;

    // Header layout: three magic bytes, then width, height and rate digits.
    localparam logic [3:0] POS_WIDTH  = 4'd3;
    localparam logic [3:0] POS_HEIGHT = 4'd6;
    localparam logic [3:0] POS_RATE   = 4'd9;
    localparam logic [3:0] POS_LAST   = 4'd10;

    // Result queue geometry.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // One result item.
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic        frame_end;
        logic [11:0] frame_width;
        logic [11:0] frame_height;
        logic [7:0]  play_rate;
        logic        full_screen;
        logic        play_reverse;
        logic [15:0] frame_total;
        logic [2:0]  status;
        logic        final_res;
    } result_t;

    // Expected magic byte at header positions zero to two.
    function automatic logic [7:0] magic_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h4C;
            2'd1:    c = 8'h41;
            default: c = 8'h46;
        endcase
        return c;
    endfunction

    // Uppercase hex digit decode: bit 4 is the valid flag, bits 3:0 the value.
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

endpackage

### rtl/text_animation_frame_parser_unit.sv
// Top level of the animation frame parser: byte parsing and result queue.
//
// Usage: file bytes arrive one per item on the item channel (item_valid,
// item_stall, data_byte, file_end); file_end marks the last byte of a file.
// Results leave on the result channel (result_valid, result_stall and the
// result fields). A byte gives zero to three results: a frame byte, an
// inserted newline after each row, a header summary on the terminator and
// an end report on the final byte of the file.
// The results of an accepted item are written into the result queue and
// offered from its head in order. Throughput: one item per cycle as long as
// results drain one per cycle; the figure is set by the four-entry result
// queue and its single read port, so items that give two or three results
// take as many queue reads. item_stall is high while more than one result
// waits in the queue. A stalled receiver holds the current result; the
// queue then fills and the block stalls its input.
// Reset puts the parser in the header phase with all counters cleared and
// empties the queue. After each end report the parser returns to that state.
module text_animation_frame_parser_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [7:0]  data_byte,
    input  logic        file_end,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  kind,
    output logic [7:0]  out_byte,
    output logic        frame_end,
    output logic [11:0] frame_width,
    output logic [11:0] frame_height,
    output logic [7:0]  play_rate,
    output logic        full_screen,
    output logic        play_reverse,
    output logic [15:0] frame_total,
    output logic [2:0]  status,
    output logic        final_res
);
    import tafp_pkg::*;

    // Parser state.
    phase_t      phase_reg, phase_next;
    logic [3:0]  header_pos_reg, header_pos_next;
    logic [11:0] width_reg, width_next;
    logic [11:0] height_reg, height_next;
    logic [7:0]  rate_reg, rate_next;
    logic [1:0]  flags_reg, flags_next;
    logic [11:0] column_reg, column_next;
    logic [11:0] row_reg, row_next;
    logic [15:0] frames_reg, frames_next;
    logic [2:0]  error_reg, error_next;

    // Result queue.
    result_t           queue_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    // Results of the current item.
    result_t    main_rec, nl_rec, rep_rec;
    logic       main_vld, nl_vld, rep_vld;
    result_t    slot [3];
    logic [1:0] push_n;
    logic       accept, pop;

    // Handshakes.
    assign item_stall   = (count_reg > QCNT_W'(1));
    assign accept       = item_valid && !item_stall;
    assign result_valid = (count_reg != '0);
    assign pop          = result_valid && !result_stall;

    // Parse one byte and form its results.
    always_comb
    begin
        logic [4:0]  hex;
        logic [7:0]  rate_tmp;
        logic [11:0] col_inc;
        logic [11:0] row_inc;
        logic [2:0]  st;

        phase_next      = phase_reg;
        header_pos_next = header_pos_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        rate_next       = rate_reg;
        flags_next      = flags_reg;
        column_next     = column_reg;
        row_next        = row_reg;
        frames_next     = frames_reg;
        error_next      = error_reg;
        main_rec        = '0;
        nl_rec          = '0;
        rep_rec         = '0;
        main_vld        = 1'b0;
        nl_vld          = 1'b0;
        rep_vld         = 1'b0;
        hex             = hex_decode(data_byte);
        rate_tmp        = {rate_reg[3:0], hex[3:0]};
        col_inc         = column_reg + 12'd1;
        row_inc         = row_reg + 12'd1;
        st              = ST_OK;

        if (data_byte != CH_LF && data_byte != CH_CR) begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (header_pos_reg < POS_WIDTH) begin
                        if (data_byte != magic_char(header_pos_reg[1:0])) begin
                            phase_next = PH_ERROR;
                            error_next = ST_MAGIC;
                        end
                    end else if (!hex[4]) begin
                        phase_next = PH_ERROR;
                        error_next = ST_HEX;
                    end else if (header_pos_reg < POS_HEIGHT) begin
                        width_next = {width_reg[7:0], hex[3:0]};
                    end else if (header_pos_reg < POS_RATE) begin
                        height_next = {height_reg[7:0], hex[3:0]};
                    end else if (header_pos_reg >= POS_LAST) begin
                        rate_next  = (rate_tmp == 8'd0) ? RATE_DEFAULT : rate_tmp;
                        phase_next = PH_OPTIONS;
                    end else begin
                        rate_next = rate_tmp;
                    end
                    if (phase_next == PH_HEADER) begin
                        header_pos_next = header_pos_reg + 4'd1;
                    end
                end
                PH_OPTIONS:
                begin
                    if (data_byte == CH_BAR) begin
                        main_vld              = 1'b1;
                        main_rec.kind         = KIND_HEADER;
                        main_rec.frame_width  = width_reg;
                        main_rec.frame_height = height_reg;
                        main_rec.play_rate    = rate_reg;
                        main_rec.full_screen  = flags_reg[0];
                        main_rec.play_reverse = flags_reg[1];
                        if (width_reg == 12'd0 || height_reg == 12'd0) begin
                            phase_next = PH_ERROR;
                            error_next = ST_LENGTH;
                        end else begin
                            phase_next = PH_CONTENT;
                        end
                    end else if (data_byte == CH_FULL) begin
                        flags_next = flags_reg | 2'b01;
                    end else if (data_byte == CH_REVERSE) begin
                        flags_next = flags_reg | 2'b10;
                    end else begin
                        phase_next = PH_ERROR;
                        error_next = ST_OPTION;
                    end
                end
                PH_CONTENT:
                begin
                    main_vld          = 1'b1;
                    main_rec.kind     = KIND_FRAME;
                    main_rec.out_byte = data_byte;
                    if (col_inc >= width_reg) begin
                        // Row complete: insert a newline, and close the frame
                        // after its last row.
                        column_next     = 12'd0;
                        nl_vld          = 1'b1;
                        nl_rec.kind     = KIND_FRAME;
                        nl_rec.out_byte = CH_LF;
                        if (row_inc >= height_reg) begin
                            nl_rec.frame_end = 1'b1;
                            row_next         = 12'd0;
                            if (frames_reg != 16'hFFFF) begin
                                frames_next = frames_reg + 16'd1;
                            end
                        end else begin
                            row_next = row_inc;
                        end
                    end else begin
                        column_next = col_inc;
                    end
                end
                PH_ERROR:
                begin
                    // Swallow everything until the end of the file.
                end
                default:
                begin
                end
            endcase
        end

        // End report on the final byte, then back to the reset state.
        if (file_end) begin
            if (phase_next == PH_ERROR) begin
                st = error_next;
            end else if (phase_next != PH_CONTENT) begin
                st = ST_TRUNCATED;
            end else if (column_next != 12'd0 || row_next != 12'd0) begin
                st = ST_LENGTH;
            end
            rep_vld             = 1'b1;
            rep_rec.kind        = KIND_END;
            rep_rec.frame_total = frames_next;
            rep_rec.status      = st;
            rep_rec.final_res   = 1'b1;
            phase_next          = PH_HEADER;
            header_pos_next     = 4'd0;
            width_next          = 12'd0;
            height_next         = 12'd0;
            rate_next           = 8'd0;
            flags_next          = 2'd0;
            column_next         = 12'd0;
            row_next            = 12'd0;
            frames_next         = 16'd0;
            error_next          = ST_OK;
        end
    end

    // Pack the results in order; a newline always follows a frame byte.
    always_comb
    begin
        slot[0] = main_vld ? main_rec : rep_rec;
        slot[1] = nl_vld ? nl_rec : rep_rec;
        slot[2] = rep_rec;
        push_n  = 2'(main_vld) + 2'(nl_vld) + 2'(rep_vld);
    end

    // Queue pointers and fill count.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (accept) begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(push_n);
            count_next  = count_next + QCNT_W'(push_n);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
            count_next  = count_next - QCNT_W'(1);
        end
    end

    // Control and parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg      <= PH_HEADER;
            header_pos_reg <= 4'd0;
            width_reg      <= 12'd0;
            height_reg     <= 12'd0;
            rate_reg       <= 8'd0;
            flags_reg      <= 2'd0;
            column_reg     <= 12'd0;
            row_reg        <= 12'd0;
            frames_reg     <= 16'd0;
            error_reg      <= ST_OK;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
        end else begin
            if (accept) begin
                phase_reg      <= phase_next;
                header_pos_reg <= header_pos_next;
                width_reg      <= width_next;
                height_reg     <= height_next;
                rate_reg       <= rate_next;
                flags_reg      <= flags_next;
                column_reg     <= column_next;
                row_reg        <= row_next;
                frames_reg     <= frames_next;
                error_reg      <= error_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage: write the packed results of an accepted item.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++) begin
            if (accept && (2'(i) < push_n)) begin
                queue_reg[wr_ptr_reg + QPTR_W'(i)] <= slot[i];
            end
        end
    end

    // Result outputs from the head of the queue.
    always_comb
    begin
        result_t head;
        head         = queue_reg[rd_ptr_reg];
        kind         = head.kind;
        out_byte     = head.out_byte;
        frame_end    = head.frame_end;
        frame_width  = head.frame_width;
        frame_height = head.frame_height;
        play_rate    = head.play_rate;
        full_screen  = head.full_screen;
        play_reverse = head.play_reverse;
        frame_total  = head.frame_total;
        status       = head.status;
        final_res    = head.final_res;
    end

endmodule

### rtl/tafp_checker.sv
// Port-level checker of the animation frame parser and its bind statement.
`include "text_animation_frame_parser_unit_macros.svh"

module tafp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic        result_stall,
    input logic [1:0]  kind,
    input logic [7:0]  out_byte,
    input logic        frame_end,
    input logic [2:0]  status,
    input logic        final_res
);
    import tafp_pkg::*;

    // A stalled result keeps its kind and byte.
    `TAFP_ASSERT_NEXT(a_stall_hold, result_valid && result_stall, result_valid && $stable(kind) && $stable(out_byte))

    // Only the end report closes a file, and it always does.
    `TAFP_ASSERT_SAME(a_final_is_end, result_valid, final_res == (kind == KIND_END))

    // A frame-end mark rides only on an inserted newline.
    `TAFP_ASSERT_SAME(a_frame_end_nl, result_valid && frame_end, kind == KIND_FRAME && out_byte == CH_LF)

    // Status is carried only by the end report.
    `TAFP_ASSERT_SAME(a_status_end, result_valid && kind != KIND_END, status == ST_OK)

endmodule

bind text_animation_frame_parser_unit tafp_checker u_tafp_checker (.*);
